// ----- design/cat_pkg.sv -----
// Shared constants for the command acknowledgement tracker: queue sizing,
// field widths, modes, character codes and event codes. No dependencies.
package cat_pkg;

	// queue sizing
	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int WIN_W    = 16;
	localparam int PERIOD_W = 17;
	localparam int EDGE_W   = 16;
	localparam int PEND_W   = 6;
	localparam int EV_W     = 4;
	localparam int ENTRY_W  = 16;

	// window length after reset, in ms
	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd5000;

	// item modes
	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_RECV = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// character codes
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	// event codes
	localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
	localparam logic [EV_W-1:0] EV_SENT     = 4'd1;
	localparam logic [EV_W-1:0] EV_ACK_OK   = 4'd2;
	localparam logic [EV_W-1:0] EV_LED      = 4'd3;
	localparam logic [EV_W-1:0] EV_NO_PEND  = 4'd4;
	localparam logic [EV_W-1:0] EV_MISMATCH = 4'd5;
	localparam logic [EV_W-1:0] EV_UNKNOWN  = 4'd6;
	localparam logic [EV_W-1:0] EV_FULL     = 4'd7;
	localparam logic [EV_W-1:0] EV_QUIT     = 4'd8;

endpackage

// ----- design/cat_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/command_ack_tracker.sv -----
// Host-side command/acknowledgement tracker for a byte link to an LED module.
// Depends on cat_pkg and cat_ram.
//
// One input word is taken at a time and yields one result word. A command or
// received byte passes through the accept cycle, in which the RAM reads the
// queue head, an execute cycle that may write the tail, a re-read of the
// new head and a capture cycle. The next word can be accepted in the cycle
// after capture.
// A window tick with a nonzero edge count also passes through a divide state
// between execute and re-read, where the bit-serial divider computes
// 2*window_ms/edge_count one quotient bit per cycle. The acknowledgement and
// command queues share one RAM of QUEUE_DEPTH 16-bit entries; only slot zero
// has a reset value (ack 'i', command space), held by one flag until written.
// A new word is accepted while the previous result still waits on the output;
// its capture then waits until that result is taken.
module command_ack_tracker import cat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [WIN_W-1:0]    cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [7:0]          byte_value,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                send_valid,
	output logic [7:0]          send_byte,
	output logic [EV_W-1:0]     event_res,
	output logic [7:0]          expected_ack,
	output logic                led_on,
	output logic [PERIOD_W-1:0] period_ms,
	output logic [EDGE_W-1:0]   edge_count,
	output logic [PEND_W-1:0]   pending,
	output logic                quit,
	output logic [7:0]          prev_sent,
	output logic [7:0]          last_received
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_CAP  = 3'd4;

	localparam logic [CNT_W:0]    DEPTH_X   = (CNT_W+1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [4:0]        DIV_LAST  = 5'(PERIOD_W - 1);

	// expected acknowledgement for a command byte, zero if unknown
	function automatic logic [7:0] expected_for(input logic [7:0] cmd);
		logic [7:0] ack;
		ack = 8'd0;
		if (cmd inside {CH_S, CH_E, [CH_ONE:CH_FIVE]}) begin
			ack = CH_A;
		end else if (cmd inside {CH_H, CH_B}) begin
			ack = cmd;
		end
		return ack;
	endfunction

	logic [2:0]          state_q;
	logic [1:0]          mode_q;
	logic [7:0]          byte_q;
	logic [WIN_W-1:0]    window_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                init_q;
	logic                rd_zero_q;
	logic                led_q;
	logic [EDGE_W-1:0]   edge_q;
	logic [PERIOD_W-1:0] period_q;
	logic                quit_q;
	logic [7:0]          sent_q;
	logic [7:0]          recv_q;
	logic                snd_v_q;
	logic [7:0]          snd_b_q;
	logic [EV_W-1:0]     ev_q;
	logic [4:0]          div_cnt_q;
	logic [EDGE_W-1:0]   div_rem_q;
	logic [PERIOD_W-1:0] div_quo_q;
	logic                out_valid_q;
	logic                cap_fire;

	// RAM signals
	logic                ram_we;
	logic [PTR_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [PTR_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	cat_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// head entry, with slot zero reset value until first written
	logic [7:0] head_ack;
	logic [7:0] head_cmd;
	always_comb begin
		if (rd_zero_q && init_q) begin
			head_ack = CH_I;
			head_cmd = CH_SPACE;
		end else begin
			head_ack = ram_rdata[15:8];
			head_cmd = ram_rdata[7:0];
		end
	end

	// tail slot and next head
	logic [CNT_W:0]   tail_sum;
	logic [PTR_W-1:0] tail_slot;
	logic [PTR_W-1:0] head_next;
	always_comb begin
		tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(cnt_q);
		if (tail_sum >= DEPTH_X) begin
			tail_slot = PTR_W'(tail_sum - DEPTH_X);
		end else begin
			tail_slot = PTR_W'(tail_sum);
		end
		head_next = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	end

	// command decode
	logic [7:0] cmd_ack;
	logic       cmd_push;
	assign cmd_ack  = expected_for(byte_q);
	assign cmd_push = (state_q == ST_EXEC) && !quit_q && (mode_q == MODE_CMD)
		&& (byte_q != CH_Q) && (cmd_ack != 8'd0) && (cnt_q != CNT_FULL);

	assign ram_we    = cmd_push;
	assign ram_waddr = tail_slot;
	assign ram_wdata = {cmd_ack, byte_q};
	assign ram_raddr = head_q;

	// event and send decode for the word in execute
	logic            exec_snd_v;
	logic [EV_W-1:0] exec_ev;
	always_comb begin
		exec_snd_v = 1'b0;
		exec_ev    = EV_NONE;
		if (!quit_q) begin
			case (mode_q)
				MODE_CMD: begin
					if (byte_q == CH_Q) begin
						exec_ev = EV_QUIT;
					end else if (cmd_ack == 8'd0) begin
						exec_ev = EV_UNKNOWN;
					end else if (cnt_q == CNT_FULL) begin
						exec_ev = EV_FULL;
					end else begin
						exec_snd_v = 1'b1;
						exec_ev    = EV_SENT;
					end
				end
				MODE_RECV: begin
					if (byte_q inside {CH_X, CH_O}) begin
						exec_ev = EV_LED;
					end else if (cnt_q == '0) begin
						exec_ev = EV_NO_PEND;
					end else if (byte_q != head_ack) begin
						exec_ev = EV_MISMATCH;
					end else if (byte_q == CH_B) begin
						exec_ev = EV_QUIT;
					end else begin
						exec_ev = EV_ACK_OK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// divider trial subtract
	logic [EDGE_W:0]   div_trial;
	logic              div_bit;
	logic [EDGE_W:0]   div_diff;
	always_comb begin
		div_trial = {div_rem_q, div_quo_q[PERIOD_W-1]};
		div_diff  = div_trial - {1'b0, edge_q};
		div_bit   = (div_trial >= {1'b0, edge_q});
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cap_fire  = (state_q == ST_CAP) && (!out_valid_q || out_ready);

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WINDOW_RESET;
			head_q      <= '0;
			cnt_q       <= CNT_W'(1);
			init_q      <= 1'b1;
			rd_zero_q   <= 1'b0;
			led_q       <= 1'b0;
			edge_q      <= '0;
			period_q    <= '0;
			quit_q      <= 1'b0;
			sent_q      <= CH_SPACE;
			recv_q      <= CH_QMARK;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_zero_q <= (ram_raddr == '0);
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			// raise valid on capture, drop it once the word is taken
			if (cap_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!quit_q && mode_q == MODE_TICK && edge_q != '0) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_READ;
					end
					if (!quit_q) begin
						case (mode_q)
							MODE_CMD: begin
								if (byte_q == CH_Q) begin
									quit_q <= 1'b1;
								end else if (cmd_push) begin
									cnt_q  <= cnt_q + 1'b1;
									sent_q <= byte_q;
									if (tail_slot == '0) begin
										init_q <= 1'b0;
									end
								end
							end
							MODE_RECV: begin
								recv_q <= byte_q;
								if (byte_q inside {CH_X, CH_O}) begin
									led_q <= (byte_q == CH_X);
									if (edge_q != '1) begin
										edge_q <= edge_q + 1'b1;
									end
								end else if (cnt_q != '0 && byte_q == head_ack) begin
									if (byte_q == CH_A
										&& (head_cmd == CH_S || head_cmd == CH_E)) begin
										led_q <= (head_cmd == CH_S);
									end else if (byte_q == CH_B) begin
										quit_q <= 1'b1;
									end
									head_q <= head_next;
									cnt_q  <= cnt_q - 1'b1;
								end
							end
							MODE_TICK: begin
								if (edge_q == '0) begin
									period_q <= '0;
								end else begin
									div_cnt_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						period_q <= {div_quo_q[PERIOD_W-2:0], div_bit};
						edge_q   <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					if (cap_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input word latch, event capture, divider datapath, result capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= mode;
			byte_q <= byte_value;
		end
		if (state_q == ST_EXEC) begin
			snd_v_q   <= exec_snd_v;
			snd_b_q   <= exec_snd_v ? byte_q : 8'd0;
			ev_q      <= exec_ev;
			div_rem_q <= '0;
			div_quo_q <= {window_q, 1'b0};
		end
		// advance one quotient bit
		if (state_q == ST_DIV) begin
			div_rem_q <= div_bit ? div_diff[EDGE_W-1:0] : div_trial[EDGE_W-1:0];
			div_quo_q <= {div_quo_q[PERIOD_W-2:0], div_bit};
		end
		// capture the result word
		if (cap_fire) begin
			send_valid    <= snd_v_q;
			send_byte     <= snd_b_q;
			event_res     <= ev_q;
			expected_ack  <= (cnt_q != '0) ? head_ack : 8'd0;
			led_on        <= led_q;
			period_ms     <= period_q;
			edge_count    <= edge_q;
			pending       <= PEND_W'(cnt_q);
			quit          <= quit_q;
			prev_sent     <= sent_q;
			last_received <= recv_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PTR_LAST)
		else $error("queue head out of range");

	a_quit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		quit_q |=> quit_q)
		else $error("quit flag dropped");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < CNT_FULL))
		else $error("queue write while full");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (edge_q != '0))
		else $error("divide by zero edge count");
`endif

endmodule

// ----- sim/command_ack_tracker_checker.sv -----
// Result checker for command_ack_tracker: watches the configuration, input and
// output ports, predicts each result word and compares it field by field.
// Depends on cat_pkg.
module command_ack_tracker_checker import cat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [WIN_W-1:0]    cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [7:0]          byte_value,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                send_valid,
	input  logic [7:0]          send_byte,
	input  logic [EV_W-1:0]     event_res,
	input  logic [7:0]          expected_ack,
	input  logic                led_on,
	input  logic [PERIOD_W-1:0] period_ms,
	input  logic [EDGE_W-1:0]   edge_count,
	input  logic [PEND_W-1:0]   pending,
	input  logic                quit,
	input  logic [7:0]          prev_sent,
	input  logic [7:0]          last_received,
	output int                  failures,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// byte that marks a command with no acknowledgement
	localparam logic [7:0] NO_ACK = 8'h00;

	typedef struct {
		logic                send_valid;
		logic [7:0]          send_byte;
		logic [EV_W-1:0]     ev;
		logic [7:0]          head_ack;
		logic                led;
		logic [PERIOD_W-1:0] period;
		logic [EDGE_W-1:0]   edges;
		logic [PEND_W-1:0]   pend;
		logic                quit;
		logic [7:0]          sent;
		logic [7:0]          rcvd;
	} report_t;

	// predicted tracker state
	logic [7:0]          ack_ring [QUEUE_DEPTH];
	logic [7:0]          cmd_ring [QUEUE_DEPTH];
	logic [PTR_W-1:0]    ring_head;
	logic [PEND_W-1:0]   ring_count;
	logic                led_q;
	logic [EDGE_W-1:0]   edge_q;
	logic [PERIOD_W-1:0] period_q;
	logic                quit_q;
	logic [7:0]          sent_q;
	logic [7:0]          rcvd_q;
	logic [WIN_W-1:0]    window_q;

	report_t predicted_reports [$];
	report_t want;
	report_t fresh;

	function automatic logic [7:0] ack_for_command(input logic [7:0] c);
		if (c == CH_S || c == CH_E || (c >= CH_ONE && c <= CH_FIVE))
			return CH_A;
		if (c == CH_H || c == CH_B)
			return c;
		return NO_ACK;
	endfunction

	// advance the tracker state by one input word and report the outcome
	function automatic report_t predict_report(input logic [1:0] m, input logic [7:0] b);
		report_t          r;
		logic [7:0]       ack;
		logic [7:0]       cmd;
		logic [31:0]      quotient;
		logic [PTR_W-1:0] slot;
		r.send_valid = 1'b0;
		r.send_byte  = 8'h00;
		r.ev         = EV_NONE;
		if (!quit_q) begin
			case (m)
				MODE_CMD: begin
					ack = ack_for_command(b);
					if (b == CH_Q) begin
						quit_q = 1'b1;
						r.ev   = EV_QUIT;
					end else if (ack == NO_ACK) begin
						r.ev = EV_UNKNOWN;
					end else if (ring_count >= QUEUE_DEPTH) begin
						r.ev = EV_FULL;
					end else begin
						slot           = PTR_W'((ring_head + ring_count) % QUEUE_DEPTH);
						ack_ring[slot] = ack;
						cmd_ring[slot] = b;
						ring_count     = ring_count + 1'b1;
						sent_q         = b;
						r.send_valid   = 1'b1;
						r.send_byte    = b;
						r.ev           = EV_SENT;
					end
				end
				MODE_RECV: begin
					rcvd_q = b;
					if (b == CH_X || b == CH_O) begin
						led_q = (b == CH_X);
						if (edge_q != '1)
							edge_q = edge_q + 1'b1;
						r.ev = EV_LED;
					end else if (ring_count == 0) begin
						r.ev = EV_NO_PEND;
					end else if (b != ack_ring[ring_head]) begin
						r.ev = EV_MISMATCH;
					end else begin
						// pop the head; 's'/'e' acks drive the LED, 'b' ends the session
						cmd  = cmd_ring[ring_head];
						r.ev = EV_ACK_OK;
						if (b == CH_A && (cmd == CH_S || cmd == CH_E)) begin
							led_q = (cmd == CH_S);
						end else if (b == CH_B) begin
							quit_q = 1'b1;
							r.ev   = EV_QUIT;
						end
						ring_head  = ring_head + 1'b1;
						ring_count = ring_count - 1'b1;
					end
				end
				MODE_TICK: begin
					if (edge_q == 0) begin
						period_q = '0;
					end else begin
						quotient = (32'd2 * window_q) / edge_q;
						period_q = quotient[PERIOD_W-1:0];
					end
					edge_q = '0;
				end
				default: ;
			endcase
		end
		r.head_ack = (ring_count != 0) ? ack_ring[ring_head] : NO_ACK;
		r.led      = led_q;
		r.period   = period_q;
		r.edges    = edge_q;
		r.pend     = ring_count;
		r.quit     = quit_q;
		r.sent     = sent_q;
		r.rcvd     = rcvd_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			failures++;
			$display("%0d ns: %s expected %0h actual %0h", $time, name, exp_v, got_v);
		end
	endtask

	// compare finished words, track the window register, predict accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_ring    = '{default: '0};
			cmd_ring    = '{default: '0};
			ack_ring[0] = CH_I;
			cmd_ring[0] = CH_SPACE;
			ring_head   = '0;
			ring_count  = PEND_W'(1);
			led_q       = 1'b0;
			edge_q      = '0;
			period_q    = '0;
			quit_q      = 1'b0;
			sent_q      = CH_SPACE;
			rcvd_q      = CH_QMARK;
			window_q    = WINDOW_RESET;
			failures    = 0;
			predicted_reports.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_reports.size() == 0) begin
					failures++;
					$display("%0d ns: result word expected none actual event %0h",
						$time, event_res);
				end else begin
					want = predicted_reports.pop_front();
					check_field("send_valid", 32'(want.send_valid), 32'(send_valid));
					check_field("send_byte", 32'(want.send_byte), 32'(send_byte));
					check_field("event_res", 32'(want.ev), 32'(event_res));
					check_field("expected_ack", 32'(want.head_ack), 32'(expected_ack));
					check_field("led_on", 32'(want.led), 32'(led_on));
					check_field("period_ms", 32'(want.period), 32'(period_ms));
					check_field("edge_count", 32'(want.edges), 32'(edge_count));
					check_field("pending", 32'(want.pend), 32'(pending));
					check_field("quit", 32'(want.quit), 32'(quit));
					check_field("prev_sent", 32'(want.sent), 32'(prev_sent));
					check_field("last_received", 32'(want.rcvd), 32'(last_received));
				end
			end
			if (cfg_we)
				window_q = cfg_data;
			if (in_valid && in_ready) begin
				fresh = predict_report(mode, byte_value);
				predicted_reports.push_back(fresh);
			end
		end
		outstanding = predicted_reports.size();
	end

endmodule

// ----- sim/command_ack_tracker_tb.sv -----
// Testbench top for command_ack_tracker: clock, reset, stimulus and verdict.
// Depends on cat_pkg, command_ack_tracker and command_ack_tracker_checker.
module command_ack_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cat_pkg::*;

	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam logic [7:0] NO_REPLY      = 8'h00;
	localparam int         CYCLE_LIMIT   = 300_000;
	localparam int         RANDOM_PHASES = 8;
	localparam int         PHASE_ITEMS   = 195;
	localparam int         LED_RUN_ITEMS = 40;
	localparam int         TAIL_WAIT     = 40;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [WIN_W-1:0]    cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic [1:0]          mode       = MODE_CMD;
	logic [7:0]          byte_value = '0;
	logic                out_ready  = 1'b0;
	logic                quiet_tail = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic                send_valid;
	logic [7:0]          send_byte;
	logic [EV_W-1:0]     event_res;
	logic [7:0]          expected_ack;
	logic                led_on;
	logic [PERIOD_W-1:0] period_ms;
	logic [EDGE_W-1:0]   edge_count;
	logic [PEND_W-1:0]   pending;
	logic                quit;
	logic [7:0]          prev_sent;
	logic [7:0]          last_received;
	int                  failures;
	int                  outstanding;
	int                  cycles = 0;
	int                  stall_left = 0;
	int                  run_left = 0;

	// acknowledgements the block still awaits, kept to shape replies
	logic [7:0] awaited_acks [$];
	bit         session_over = 1'b0;

	command_ack_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.byte_value    (byte_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.send_valid    (send_valid),
		.send_byte     (send_byte),
		.event_res     (event_res),
		.expected_ack  (expected_ack),
		.led_on        (led_on),
		.period_ms     (period_ms),
		.edge_count    (edge_count),
		.pending       (pending),
		.quit          (quit),
		.prev_sent     (prev_sent),
		.last_received (last_received)
	);

	command_ack_tracker_checker tracker_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.byte_value    (byte_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.send_valid    (send_valid),
		.send_byte     (send_byte),
		.event_res     (event_res),
		.expected_ack  (expected_ack),
		.led_on        (led_on),
		.period_ms     (period_ms),
		.edge_count    (edge_count),
		.pending       (pending),
		.quit          (quit),
		.prev_sent     (prev_sent),
		.last_received (last_received),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stall the result side in random bursts, hold ready high in the tail
	always @(posedge clk) begin
		if (quiet_tail) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (run_left > 0)
				run_left--;
			else if ($urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 7);
			else
				run_left = $urandom_range(0, 24);
		end
	end

	function automatic logic [7:0] reply_for(input logic [7:0] c);
		if (c == CH_S || c == CH_E || (c >= CH_ONE && c <= CH_FIVE))
			return CH_A;
		if (c == CH_H || c == CH_B)
			return c;
		return NO_REPLY;
	endfunction

	// commands that are sent and answered without ending the session
	function automatic logic [7:0] known_command();
		int k;
		k = $urandom_range(0, 7);
		case (k)
			0:       return CH_S;
			1:       return CH_E;
			2:       return CH_H;
			default: return 8'(CH_ONE + k - 3);
		endcase
	endfunction

	// offer one word, hold it until accepted, then track the awaited acks
	task automatic send_word(input logic [1:0] m, input logic [7:0] b);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		byte_value <= b;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		if (!session_over) begin
			if (m == MODE_CMD) begin
				if (b == CH_Q)
					session_over = 1'b1;
				else if (reply_for(b) != NO_REPLY && awaited_acks.size() < QUEUE_DEPTH)
					awaited_acks.push_back(reply_for(b));
			end else if (m == MODE_RECV && b != CH_X && b != CH_O
					&& awaited_acks.size() != 0 && b == awaited_acks[0]) begin
				awaited_acks.delete(0);
				if (b == CH_B)
					session_over = 1'b1;
			end
		end
	endtask

	// drop valid and wait until every predicted word has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random word; filling phases favor commands, draining phases replies
	task automatic random_word(input bit filling);
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < (filling ? 45 : 20)) begin
			send_word(MODE_CMD, known_command());
		end else if (pick < (filling ? 55 : 25)) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_Q || b == CH_B);
			send_word(MODE_CMD, b);
		end else if (pick < (filling ? 75 : 65)) begin
			if (awaited_acks.size() != 0)
				send_word(MODE_RECV, awaited_acks[0]);
			else
				send_word(MODE_RECV, 8'($urandom_range(0, 255)));
		end else if (pick < (filling ? 85 : 80)) begin
			send_word(MODE_RECV, $urandom_range(0, 1) ? CH_X : CH_O);
		end else if (pick < 92) begin
			send_word(MODE_RECV, 8'($urandom_range(0, 255)));
		end else if (pick < 97) begin
			send_word(MODE_TICK, 8'($urandom_range(0, 255)));
		end else begin
			send_word(MODE_UNUSED, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		awaited_acks.push_back(CH_I);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words with the window at its reset length
		send_word(MODE_TICK, 8'h00);        // no edges: period stays zero
		send_word(MODE_UNUSED, 8'hFF);      // unused mode changes nothing
		send_word(MODE_RECV, CH_QMARK);     // mismatch against the reset entry
		send_word(MODE_RECV, CH_I);         // reset entry acknowledged
		send_word(MODE_RECV, CH_A);         // nothing pending
		send_word(MODE_CMD, 8'h00);
		send_word(MODE_CMD, 8'hFF);
		send_word(MODE_CMD, 8'(CH_ONE - 1));  // just outside the digit commands
		send_word(MODE_CMD, 8'(CH_FIVE + 1));
		send_word(MODE_CMD, CH_S);
		send_word(MODE_CMD, CH_E);
		send_word(MODE_CMD, CH_ONE);
		send_word(MODE_CMD, CH_FIVE);
		send_word(MODE_CMD, CH_H);
		send_word(MODE_RECV, CH_H);         // head still awaits 'a'
		send_word(MODE_RECV, CH_A);         // 's' acknowledged: LED on
		send_word(MODE_RECV, CH_X);
		send_word(MODE_RECV, CH_O);
		send_word(MODE_RECV, CH_A);         // 'e' acknowledged: LED off
		send_word(MODE_RECV, CH_A);
		send_word(MODE_RECV, CH_A);
		send_word(MODE_RECV, CH_H);
		send_word(MODE_TICK, 8'hFF);        // period from the 'x'/'o' edge count so far
		send_word(MODE_RECV, 8'hFF);
		send_word(MODE_RECV, 8'h00);

		// random phases, each under its own window length
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0, 5:    write_window(16'hFFFF);
				1:       write_window(16'd1);
				3:       write_window(16'd2);
				default: write_window(16'($urandom_range(1, 65535)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_word(p % 2 == 0);
		end

		// a run of LED updates inside one long window
		write_window(16'hFFFF);
		quiet_tail <= 1'b1;
		send_word(MODE_TICK, 8'h00);
		for (int n = 0; n < LED_RUN_ITEMS; n++)
			send_word(MODE_RECV, $urandom_range(0, 1) ? CH_X : CH_O);
		send_word(MODE_TICK, 8'h00);

		// drain the queue, end the session, then confirm words are ignored
		while (awaited_acks.size() != 0)
			send_word(MODE_RECV, awaited_acks[0]);
		if ($urandom_range(0, 1)) begin
			send_word(MODE_CMD, CH_Q);
		end else begin
			send_word(MODE_CMD, CH_B);
			send_word(MODE_RECV, CH_B);
		end
		send_word(MODE_CMD, CH_S);
		send_word(MODE_RECV, CH_X);
		send_word(MODE_RECV, CH_A);
		send_word(MODE_TICK, 8'h00);
		send_word(MODE_CMD, CH_Q);

		settle();
		repeat (TAIL_WAIT) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- command_ack_tracker.f -----
design/cat_pkg.sv
design/cat_ram.sv
design/command_ack_tracker.sv
sim/command_ack_tracker_checker.sv
sim/command_ack_tracker_tb.sv
